[hdl/mrd_pkg.sv]
package mrd_pkg;

   typedef enum logic [1:0] {
      FIELD_TYPE   = 2'd0,
      FIELD_LABEL  = 2'd1,
      FIELD_LENGTH = 2'd2
   } hdr_field_type;

   localparam logic [1:0] STAGE_FIRST  = 2'd0;
   localparam logic [1:0] STAGE_SECOND = 2'd1;
   localparam logic [1:0] STAGE_THIRD  = 2'd2;

   localparam int SKIP_W = 29;
   localparam int ACC_W  = 32;
   localparam int LEFT_W = 6;
   localparam int LEN_W  = SKIP_W - 3;

   typedef struct packed {
      hdr_field_type     field;
      logic [1:0]        stage;
      logic [LEFT_W-1:0] left;
      logic [ACC_W-1:0]  acc;
      logic              rap;
      logic [SKIP_W-1:0] skip;
   } core_state_type;

   typedef struct packed {
      hdr_field_type     field;
      logic [1:0]        stage;
      logic [LEFT_W-1:0] left;
      logic [ACC_W-1:0]  acc;
      logic              rap;
      logic              skipping;
      logic [SKIP_W-1:0] skip_set;
      logic [2:0]        skip_cnt;
   } walk_state_type;

   typedef struct packed {
      logic is_rap;
      logic truncated;
   } rsp_payload_type;

   function automatic logic [LEFT_W-1:0] part_width(hdr_field_type f, logic [1:0] s);
      logic [LEFT_W-1:0] w;
      w = 6'd3;
      unique case (f)
         FIELD_TYPE: begin
            w = (s == STAGE_FIRST) ? 6'd3 : 6'd8;
         end
         FIELD_LABEL: begin
            if (s == STAGE_FIRST) w = 6'd2;
            else if (s == STAGE_SECOND) w = 6'd8;
            else w = 6'd32;
         end
         FIELD_LENGTH: begin
            w = (s == STAGE_FIRST) ? 6'd11 : 6'd24;
         end
         default: w = 6'd3;
      endcase
      return w;
   endfunction

   function automatic logic [ACC_W-1:0] part_ones(logic [LEFT_W-1:0] w);
      logic [ACC_W:0] m;
      m = ({{ACC_W{1'b0}}, 1'b1} << w) - {{ACC_W{1'b0}}, 1'b1};
      return m[ACC_W-1:0];
   endfunction

   function automatic logic [LEN_W-1:0] length_offset(logic [1:0] s);
      logic [LEN_W-1:0] o;
      o = '0;
      unique case (s)
         STAGE_FIRST:  o = LEN_W'(0);
         STAGE_SECOND: o = LEN_W'(2047);
         STAGE_THIRD:  o = LEN_W'(2047 + 16777215);
         default:      o = '0;
      endcase
      return o;
   endfunction

endpackage

[hdl/mrd_if.sv]
interface mrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source(output valid, output data_byte, output last_byte, input ready);
   modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface mrd_rsp_if;
   logic valid;
   logic ready;
   logic is_rap;
   logic truncated;

   modport source(output valid, output is_rap, output truncated, input ready);
   modport sink(input valid, input is_rap, input truncated, output ready);
endinterface

[hdl/mhas_rap_detector_unit.sv]
// Random access point detector for packetized audio frames. Feed the frame one byte per item,
// marking the final byte with last_byte; the unit walks the packet header chain (escaped type,
// label and length, then skips length*8 payload bits at any bit offset) and, on the last byte,
// returns one item with is_rap and truncated, then restarts for the next frame. Throughput is
// one byte per clock: all eight bit steps of a byte resolve combinationally between the parser
// state register and a two-entry result queue, so a frame's result is registered into the queue
// as its last byte is taken. req ready drops only while both queue entries are occupied.
module mhas_rap_detector_unit (
   input  logic            clock,
   input  logic            reset,
   mrd_req_if.sink         req_chan,
   mrd_rsp_if.source       rsp_chan
);

   mrd_pkg::core_state_type  st_ff, st_in;
   mrd_pkg::rsp_payload_type head_ff, head_in, tail_ff, tail_in, result;
   logic                     head_vld_ff, head_vld_in, tail_vld_ff, tail_vld_in;
   mrd_pkg::walk_state_type  walk;
   logic [3:0]               prefix;
   logic [mrd_pkg::SKIP_W-1:0] skip_base, skip_new;
   logic                     accept, push, pop;

   function automatic mrd_pkg::walk_state_type start_field(mrd_pkg::walk_state_type w,
                                                            mrd_pkg::hdr_field_type f);
      mrd_pkg::walk_state_type r;
      r       = w;
      r.field = f;
      r.stage = mrd_pkg::STAGE_FIRST;
      r.left  = mrd_pkg::part_width(f, mrd_pkg::STAGE_FIRST);
      r.acc   = '0;
      return r;
   endfunction

   function automatic mrd_pkg::walk_state_type step_bit(mrd_pkg::walk_state_type w,
                                                         logic b);
      mrd_pkg::walk_state_type r;
      logic [mrd_pkg::ACC_W-1:0]  acc_n;
      logic [mrd_pkg::LEN_W-1:0]  len;
      r = w;
      if (w.rap) begin
         r = w;
      end else if (w.skipping) begin
         r.skip_cnt = w.skip_cnt + 3'd1;
      end else begin
         acc_n  = {w.acc[mrd_pkg::ACC_W-2:0], b};
         r.acc  = acc_n;
         r.left = w.left - 6'd1;
         if (r.left == '0) begin
            if (w.stage != mrd_pkg::STAGE_THIRD &&
                acc_n == mrd_pkg::part_ones(mrd_pkg::part_width(w.field, w.stage))) begin
               r.stage = w.stage + 2'd1;
               r.left  = mrd_pkg::part_width(w.field, w.stage + 2'd1);
               r.acc   = '0;
            end else begin
               unique case (w.field)
                  mrd_pkg::FIELD_TYPE: begin
                     if (w.stage == mrd_pkg::STAGE_FIRST &&
                         acc_n == mrd_pkg::ACC_W'(1)) begin
                        r.rap = 1'b1;
                     end else begin
                        r = start_field(r, mrd_pkg::FIELD_LABEL);
                     end
                  end
                  mrd_pkg::FIELD_LABEL: begin
                     r = start_field(r, mrd_pkg::FIELD_LENGTH);
                  end
                  mrd_pkg::FIELD_LENGTH: begin
                     len        = mrd_pkg::length_offset(w.stage) +
                                  acc_n[mrd_pkg::LEN_W-1:0];
                     r.skip_set = {len, 3'b000};
                     r.skipping = (len != '0);
                     r.skip_cnt = 3'd0;
                     r          = start_field(r, mrd_pkg::FIELD_TYPE);
                  end
                  default: begin
                     r = start_field(r, mrd_pkg::FIELD_TYPE);
                  end
               endcase
            end
         end
      end
      return r;
   endfunction

   always_comb begin
      prefix    = (st_ff.skip >= mrd_pkg::SKIP_W'(8)) ? 4'd8 : {1'b0, st_ff.skip[2:0]};
      skip_base = st_ff.skip - {{(mrd_pkg::SKIP_W-4){1'b0}}, prefix};
      walk.field    = st_ff.field;
      walk.stage    = st_ff.stage;
      walk.left     = st_ff.left;
      walk.acc      = st_ff.acc;
      walk.rap      = st_ff.rap;
      walk.skipping = 1'b0;
      walk.skip_set = '0;
      walk.skip_cnt = '0;
      for (int j = 0; j < 8; j++) begin
         if (4'(j) >= prefix) begin
            walk = step_bit(walk, req_chan.data_byte[3'(7 - j)]);
         end
      end
      skip_new = walk.skipping ?
                 walk.skip_set - {{(mrd_pkg::SKIP_W-3){1'b0}}, walk.skip_cnt} : skip_base;
      result.is_rap    = walk.rap;
      result.truncated = !walk.rap && skip_new == '0 &&
                         !(walk.field == mrd_pkg::FIELD_TYPE &&
                           walk.stage == mrd_pkg::STAGE_FIRST &&
                           walk.left == mrd_pkg::part_width(mrd_pkg::FIELD_TYPE,
                                                            mrd_pkg::STAGE_FIRST));
   end

   assign req_chan.ready = !tail_vld_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push           = accept && req_chan.last_byte;
   assign pop            = head_vld_ff && rsp_chan.ready;

   always_comb begin
      st_in = st_ff;
      if (accept) begin
         if (req_chan.last_byte) begin
            st_in.field = mrd_pkg::FIELD_TYPE;
            st_in.stage = mrd_pkg::STAGE_FIRST;
            st_in.left  = mrd_pkg::part_width(mrd_pkg::FIELD_TYPE, mrd_pkg::STAGE_FIRST);
            st_in.acc   = '0;
            st_in.rap   = 1'b0;
            st_in.skip  = '0;
         end else begin
            st_in.field = walk.field;
            st_in.stage = walk.stage;
            st_in.left  = walk.left;
            st_in.acc   = walk.acc;
            st_in.rap   = walk.rap;
            st_in.skip  = skip_new;
         end
      end
   end

   always_comb begin
      head_vld_in = head_vld_ff;
      tail_vld_in = tail_vld_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      if (pop) begin
         head_vld_in = tail_vld_ff;
         head_in     = tail_ff;
         tail_vld_in = 1'b0;
      end
      if (push) begin
         if (!head_vld_in) begin
            head_vld_in = 1'b1;
            head_in     = result;
         end else begin
            tail_vld_in = 1'b1;
            tail_in     = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.field <= mrd_pkg::FIELD_TYPE;
         st_ff.stage <= mrd_pkg::STAGE_FIRST;
         st_ff.left  <= mrd_pkg::part_width(mrd_pkg::FIELD_TYPE, mrd_pkg::STAGE_FIRST);
         st_ff.acc   <= '0;
         st_ff.rap   <= 1'b0;
         st_ff.skip  <= '0;
         head_vld_ff <= 1'b0;
         tail_vld_ff <= 1'b0;
      end else begin
         st_ff       <= st_in;
         head_vld_ff <= head_vld_in;
         tail_vld_ff <= tail_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_chan.valid     = head_vld_ff;
   assign rsp_chan.is_rap    = head_ff.is_rap;
   assign rsp_chan.truncated = head_ff.truncated;

   a_tail_needs_head: assert property (@(posedge clock) disable iff (reset)
      tail_vld_ff |-> head_vld_ff)
      else $error("second queue entry held without a first");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      push |=> (st_ff.field == mrd_pkg::FIELD_TYPE && st_ff.stage == mrd_pkg::STAGE_FIRST &&
                !st_ff.rap && st_ff.skip == '0))
      else $error("parser did not restart after the last byte");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      push |=> head_vld_ff)
      else $error("last byte left no result in the queue");

   a_part_open: assert property (@(posedge clock) disable iff (reset)
      st_ff.rap || (st_ff.left != '0 && st_ff.stage <= mrd_pkg::STAGE_THIRD))
      else $error("parser holds a finished or invalid part");

endmodule

[sim/tb_mhas_rap_detector_unit.sv]
`timescale 1ns / 100ps

module tb_mhas_rap_detector_unit;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int STALL_CYCLES   = 400;
   localparam int TAIL_CYCLES    = 16;
   localparam int PHASE_ITEMS    = 580;
   localparam int MAX_REPORTS    = 10;
   localparam int LONG_BYTES     = 48;

   localparam int PART_BITS [3][3] = '{'{3, 8, 8}, '{2, 8, 32}, '{11, 24, 24}};

   // flags: typed, is_rap, truncated, last_byte
   localparam logic [11:0] DIRECTED [21] = '{
      {4'b1101, 8'h20},
      {4'b1011, 8'h00},
      {4'b1011, 8'hFF},
      {4'b0000, 8'h00}, {4'b1001, 8'h00},
      {4'b0000, 8'h00}, {4'b0000, 8'h01}, {4'b0000, 8'hAB}, {4'b1101, 8'h20},
      {4'b0000, 8'h3F}, {4'b1101, 8'hFF},
      {4'b0000, 8'h07}, {4'b0000, 8'hFF}, {4'b0000, 8'hFF}, {4'b0000, 8'hFF},
      {4'b0000, 8'hFF}, {4'b0000, 8'hFF}, {4'b0000, 8'hFF}, {4'b1001, 8'hFF},
      {4'b0000, 8'hE0}, {4'b0001, 8'h40}
   };

   typedef struct {
      logic [7:0]               data;
      logic                     last;
      bit                       typed;
      mrd_pkg::rsp_payload_type want;
   } frame_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     drv_valid = 1'b0;
   logic [7:0]               drv_data  = '0;
   logic                     drv_last  = 1'b0;
   bit                       drv_typed = 1'b0;
   mrd_pkg::rsp_payload_type drv_want  = '0;
   logic                     drv_ready = 1'b0;

   mrd_req_if req_if();
   mrd_rsp_if rsp_if();

   assign req_if.valid     = drv_valid;
   assign req_if.data_byte = drv_data;
   assign req_if.last_byte = drv_last;
   assign rsp_if.ready     = drv_ready;

   mhas_rap_detector_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   frame_byte_type           byte_q[$];
   mrd_pkg::rsp_payload_type verdict_q[$];
   bit                       bit_q[$];
   bit                       long_done;

   int send_idle;
   int recv_idle;
   bit stall_go;
   int stall_left   = 0;
   bit stall_taken  = 1'b0;
   int mismatch_cnt = 0;
   int quiet_cycles = 0;

   bit                       frame_done;
   mrd_pkg::rsp_payload_type predicted;
   mrd_pkg::rsp_payload_type expected_v;
   mrd_pkg::rsp_payload_type observed;

   mrd_pkg::hdr_field_type w_field;
   logic [1:0]             w_stage;
   logic [5:0]             w_left;
   logic [31:0]            w_acc;
   logic [33:0]            w_sum;
   logic [28:0]            w_skip;
   logic                   w_rap;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic open_field(mrd_pkg::hdr_field_type f);
      w_field = f;
      w_stage = mrd_pkg::STAGE_FIRST;
      w_left  = 6'(PART_BITS[int'(f)][int'(mrd_pkg::STAGE_FIRST)]);
      w_acc   = '0;
      w_sum   = '0;
   endtask

   task automatic clear_walker();
      w_skip = '0;
      w_rap  = 1'b0;
      open_field(mrd_pkg::FIELD_TYPE);
   endtask

   task automatic walk_bit(logic b);
      logic [32:0] ones;
      if (w_rap) begin
         ones = '0;
      end else if (w_skip != 0) begin
         w_skip = w_skip - 1'b1;
      end else begin
         w_acc = {w_acc[30:0], b};
         if (w_left != 0) w_left = w_left - 1'b1;
         if (w_left == 0) begin
            ones  = (33'd1 << PART_BITS[int'(w_field)][int'(w_stage)]) - 33'd1;
            w_sum = w_sum + {2'b00, w_acc};
            if (w_stage != mrd_pkg::STAGE_THIRD && {1'b0, w_acc} == ones) begin
               w_stage = w_stage + 1'b1;
               w_left  = 6'(PART_BITS[int'(w_field)][int'(w_stage)]);
               w_acc   = '0;
            end else if (w_field == mrd_pkg::FIELD_TYPE) begin
               if (w_sum == 34'd1) w_rap = 1'b1;
               else open_field(mrd_pkg::FIELD_LABEL);
            end else if (w_field == mrd_pkg::FIELD_LABEL) begin
               open_field(mrd_pkg::FIELD_LENGTH);
            end else begin
               w_skip = {w_sum[25:0], 3'b000};
               open_field(mrd_pkg::FIELD_TYPE);
            end
         end
      end
   endtask

   task automatic walk_byte(input logic [7:0] d, input logic last_in, output bit done,
                            output mrd_pkg::rsp_payload_type v);
      v = '0;
      for (int i = 7; i >= 0; i--) walk_bit(d[i]);
      done = last_in;
      if (last_in) begin
         v.is_rap    = w_rap;
         v.truncated = !w_rap && w_skip == 0 &&
                       !(w_field == mrd_pkg::FIELD_TYPE && w_stage == mrd_pkg::STAGE_FIRST &&
                         w_left == 6'(PART_BITS[int'(mrd_pkg::FIELD_TYPE)]
                                               [int'(mrd_pkg::STAGE_FIRST)]));
         clear_walker();
      end
   endtask

   task automatic put_bits(logic [31:0] v, int n);
      for (int i = n - 1; i >= 0; i--) bit_q.push_back(v[i]);
   endtask

   task automatic put_field(mrd_pkg::hdr_field_type f, int stages, logic [31:0] tail,
                            output longint sum);
      logic [32:0] ones;
      sum = 0;
      for (int s = 0; s <= stages; s++) begin
         ones = (33'd1 << PART_BITS[int'(f)][s]) - 33'd1;
         if (s < stages) begin
            put_bits(ones[31:0], PART_BITS[int'(f)][s]);
            sum += ones;
         end else begin
            put_bits(tail, PART_BITS[int'(f)][s]);
            sum += tail;
         end
      end
   endtask

   function automatic int pick_stage();
      int r;
      r = $urandom_range(0, 9);
      return (r < 8) ? 0 : r - 7;
   endfunction

   function automatic logic [31:0] pick_tail(mrd_pkg::hdr_field_type f, int s);
      logic [32:0] ones;
      ones = (33'd1 << PART_BITS[int'(f)][s]) - 33'd1;
      if (s == 2) return $urandom() & ones[31:0];
      return $urandom_range(0, ones[31:0] - 1);
   endfunction

   task automatic gen_frame(bit allow_long);
      int             npk;
      int             nbytes;
      int             ts;
      int             r;
      bit             huge;
      bit             long_frame;
      longint         fv;
      longint         nv;
      logic [31:0]    tail;
      frame_byte_type it;
      bit_q.delete();
      huge       = 1'b0;
      long_frame = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) put_bits($urandom(), 8);
      end else begin
         npk = $urandom_range(0, 3);
         for (int p = 0; p < npk && !huge; p++) begin
            ts = pick_stage();
            tail = pick_tail(mrd_pkg::FIELD_TYPE, ts);
            if (ts == 0) tail = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(2, 6);
            put_field(mrd_pkg::FIELD_TYPE, ts, tail, fv);
            ts = pick_stage();
            put_field(mrd_pkg::FIELD_LABEL, ts, pick_tail(mrd_pkg::FIELD_LABEL, ts), fv);
            r = $urandom_range(0, 24);
            if (r == 0) begin
               put_field(mrd_pkg::FIELD_LENGTH, 2, pick_tail(mrd_pkg::FIELD_LENGTH, 2), nv);
               huge = 1'b1;
            end else if (r == 1 && allow_long && !long_done) begin
               if ($urandom_range(0, 1) == 1) put_field(mrd_pkg::FIELD_LENGTH, 0, 2046, nv);
               else put_field(mrd_pkg::FIELD_LENGTH, 1, $urandom_range(0, 2), nv);
               long_done  = 1'b1;
               long_frame = 1'b1;
            end else begin
               put_field(mrd_pkg::FIELD_LENGTH, 0, $urandom_range(0, 12), nv);
            end
            if (huge) put_bits($urandom(), $urandom_range(0, 30));
            else for (longint k = 0; k < nv * 8; k++) bit_q.push_back($urandom_range(0, 1));
         end
         if (!huge && (npk == 0 || $urandom_range(0, 1) == 1)) begin
            put_bits(1, 3);
            put_bits($urandom(), $urandom_range(0, 31));
         end
      end
      while (bit_q.size() % 8 != 0) bit_q.push_back($urandom_range(0, 1));
      nbytes = bit_q.size() / 8;
      if (nbytes > 1 && $urandom_range(0, 4) == 0) nbytes = $urandom_range(1, nbytes - 1);
      if (long_frame && nbytes > LONG_BYTES) nbytes = LONG_BYTES;
      for (int b = 0; b < nbytes; b++) begin
         for (int i = 0; i < 8; i++) it.data[7 - i] = bit_q[b * 8 + i];
         it.last  = (b == nbytes - 1);
         it.typed = 1'b0;
         it.want  = '0;
         byte_q.push_back(it);
      end
   endtask

   task automatic fill_phase(bit allow_long);
      while (byte_q.size() < PHASE_ITEMS) gen_frame(allow_long);
   endtask

   task automatic drain();
      while (byte_q.size() != 0 || drv_valid || verdict_q.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!drv_valid || req_if.ready) begin
         if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
            drv_valid <= 1'b1;
            drv_data  <= byte_q[0].data;
            drv_last  <= byte_q[0].last;
            drv_typed <= byte_q[0].typed;
            drv_want  <= byte_q[0].want;
            void'(byte_q.pop_front());
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         drv_ready <= 1'b0;
      end else begin
         if (stall_go && !stall_taken) begin
            stall_left  = STALL_CYCLES;
            stall_taken = 1'b1;
         end
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            drv_ready <= 1'b0;
         end else begin
            drv_ready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_walker();
      end else begin
         if (req_if.valid && req_if.ready) begin
            walk_byte(req_if.data_byte, req_if.last_byte, frame_done, predicted);
            if (frame_done) verdict_q.push_back(drv_typed ? drv_want : predicted);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            observed.is_rap    = rsp_if.is_rap;
            observed.truncated = rsp_if.truncated;
            if (verdict_q.size() == 0) begin
               if (mismatch_cnt < MAX_REPORTS)
                  $display("unexpected item: is_rap=%b truncated=%b",
                           observed.is_rap, observed.truncated);
               mismatch_cnt++;
            end else begin
               expected_v = verdict_q.pop_front();
               if (observed.is_rap !== expected_v.is_rap ||
                   observed.truncated !== expected_v.truncated) begin
                  if (mismatch_cnt < MAX_REPORTS)
                     $display("mismatch: want is_rap=%b truncated=%b, got %b %b",
                              expected_v.is_rap, expected_v.truncated,
                              observed.is_rap, observed.truncated);
                  mismatch_cnt++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[mhas_rap_detector_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      frame_byte_type it;
      send_idle    = 0;
      recv_idle    = 0;
      stall_go     = 1'b0;
      long_done    = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);

      foreach (DIRECTED[i]) begin
         it.data           = DIRECTED[i][7:0];
         it.last           = DIRECTED[i][8];
         it.want.truncated = DIRECTED[i][9];
         it.want.is_rap    = DIRECTED[i][10];
         it.typed          = DIRECTED[i][11];
         byte_q.push_back(it);
      end
      drain();

      send_idle = 38;
      recv_idle = 56;
      fill_phase(1'b0);
      drain();

      // hold the receiver off so the result queue fills and backs up the input
      send_idle = 56;
      recv_idle = 38;
      fill_phase(1'b0);
      stall_go = 1'b1;
      drain();

      send_idle = 0;
      recv_idle = 0;
      fill_phase(1'b1);
      drain();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
         $display("[mhas_rap_detector_unit] OK");
      end else begin
         $display("[mhas_rap_detector_unit] ERROR");
      end
      $finish;
   end

endmodule
